// ----- rtl/pslwd_pkg.sv -----
// Shared types and constants for the per-stream loss window dropper.
// Holds the controller/datapath command and status structs and register indexes.
// No dependencies.
package pslwd_pkg;

	localparam logic [15:0] DATA_FRAME_TYPE = 16'd1;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_LOSS_TERM_ID     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOSS_TERM_OFFSET = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOSS_LENGTH      = 2'd2;

	localparam int KEY_W    = 64;
	localparam int OFFSET_W = 33;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic take_hit;
		logic alloc;
		logic eval;
		logic res_none;
		logic res_full;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic considered;
		logic table_empty;
		logic table_full;
		logic hit;
		logic scan_miss;
	} dp_stat_t;

endpackage

// ----- rtl/pslwd_ifs.sv -----
// Channel interfaces of the dropper: request, result and register write.
// Depends on pslwd_pkg for the register index width.
interface pslwd_req_if;
	logic               valid;
	logic               ready;
	logic [15:0]        frame_type;
	logic signed [31:0] frame_term_id;
	logic [30:0]        frame_term_offset;
	logic signed [31:0] strm_id;
	logic signed [31:0] sess_id;
	logic [15:0]        datagram_length;

	modport source (output valid, frame_type, frame_term_id, frame_term_offset,
		strm_id, sess_id, datagram_length, input ready);
	modport sink (input valid, frame_type, frame_term_id, frame_term_offset,
		strm_id, sess_id, datagram_length, output ready);
endinterface

interface pslwd_res_if;
	logic valid;
	logic ready;
	logic drop;
	logic table_full;

	modport source (output valid, drop, table_full, input ready);
	modport sink (input valid, drop, table_full, output ready);
endinterface

interface pslwd_cfg_if;
	logic        valid;
	logic        ready;
	logic [pslwd_pkg::CFG_INDEX_W-1:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/pslwd_ctrl.sv -----
// Controller of the dropper: sequences request capture, table scan,
// allocation, window check and result hand-off. Depends on pslwd_pkg.
module pslwd_ctrl
	import pslwd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     res_valid,
	input  logic     res_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_valid_q;
	logic       out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign out_free  = !res_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!stat.considered) begin
					cmd.res_none = 1'b1;
					state_d      = ST_DONE;
				end else if (stat.table_empty) begin
					cmd.alloc = 1'b1;
					state_d   = ST_EVAL;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = ST_EVAL;
				end else if (stat.scan_miss) begin
					if (stat.table_full) begin
						cmd.res_full = 1'b1;
						state_d      = ST_DONE;
					end else begin
						cmd.alloc = 1'b1;
						state_d   = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/pslwd_dp.sv -----
// Datapath of the dropper: loss window registers, request registers, stream
// table memory with scan pointer and fill count, window check, result register.
// Depends on pslwd_pkg.
module pslwd_dp
	import pslwd_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16,
	parameter int CW = $clog2(TABLE_ENTRIES + 1),
	parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	input  logic [15:0]            frame_type,
	input  logic signed [31:0]     frame_term_id,
	input  logic [30:0]            frame_term_offset,
	input  logic signed [31:0]     strm_id,
	input  logic signed [31:0]     sess_id,
	input  logic [15:0]            datagram_length,
	input  dp_cmd_t                cmd,
	output dp_stat_t               stat,
	output logic [CW-1:0]          fill,
	output logic                   drop,
	output logic                   table_full
);

	localparam int ENTRY_W = KEY_W + OFFSET_W;

	logic [31:0]          loss_term_id_q;
	logic [30:0]          loss_term_offset_q;
	logic [31:0]          loss_length_q;

	logic [15:0]          type_q;
	logic [31:0]          term_id_q;
	logic [30:0]          foff_q;
	logic [KEY_W-1:0]     key_q;
	logic [15:0]          dlen_q;

	logic [ENTRY_W-1:0]   mem_q [TABLE_ENTRIES];
	logic [ENTRY_W-1:0]   rd_data_s1;
	logic                 rd_pend_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 rd_en;
	logic [CW-1:0]        scan_idx_q;
	logic [CW-1:0]        fill_q;

	logic [AW-1:0]        hit_idx_q;
	logic [OFFSET_W-1:0]  track_q;
	logic                 is_new_q;

	logic [OFFSET_W-1:0]  window_end;
	logic [OFFSET_W-1:0]  frame_end;
	logic                 drop_now;
	logic                 key_match;

	logic                 res_drop_q;
	logic                 res_full_q;
	logic                 out_drop_q;
	logic                 out_full_q;

	assign fill       = fill_q;
	assign drop       = out_drop_q;
	assign table_full = out_full_q;

	assign rd_en     = cmd.scan_step && (scan_idx_q < fill_q);
	assign key_match = (rd_data_s1[ENTRY_W-1:OFFSET_W] == key_q);

	assign stat.considered  = (type_q == DATA_FRAME_TYPE) && (term_id_q == loss_term_id_q);
	assign stat.table_empty = (fill_q == '0);
	assign stat.table_full  = (fill_q == CW'(TABLE_ENTRIES));
	assign stat.hit         = rd_pend_s1 && key_match;
	assign stat.scan_miss   = rd_pend_s1 && !key_match &&
		((CW'(rd_idx_s1) + CW'(1)) == fill_q);

	assign window_end = {2'b00, loss_term_offset_q} + {1'b0, loss_length_q};
	assign frame_end  = {2'b00, foff_q} + {17'd0, dlen_q};
	assign drop_now   = (track_q < window_end) && ({2'b00, foff_q} <= track_q) &&
		(track_q < frame_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_term_id_q     <= '0;
			loss_term_offset_q <= '0;
			loss_length_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOSS_TERM_ID:     loss_term_id_q     <= cfg_data;
				REG_LOSS_TERM_OFFSET: loss_term_offset_q <= cfg_data[30:0];
				REG_LOSS_LENGTH:      loss_length_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q    <= frame_type;
			term_id_q <= frame_term_id;
			foff_q    <= frame_term_offset;
			key_q     <= {strm_id, sess_id};
			dlen_q    <= datagram_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			scan_idx_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
				rd_pend_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rd_pend_s1 <= rd_en;
				if (rd_en) begin
					scan_idx_q <= scan_idx_q + CW'(1);
				end
			end
			if (cmd.eval && is_new_q) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[scan_idx_q[AW-1:0]];
			rd_idx_s1  <= scan_idx_q[AW-1:0];
		end
		if (cmd.eval) begin
			mem_q[hit_idx_q] <= {key_q, drop_now ? frame_end : track_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_hit) begin
			hit_idx_q <= rd_idx_s1;
			track_q   <= rd_data_s1[OFFSET_W-1:0];
			is_new_q  <= 1'b0;
		end else if (cmd.alloc) begin
			hit_idx_q <= fill_q[AW-1:0];
			track_q   <= {2'b00, foff_q};
			is_new_q  <= 1'b1;
		end
		if (cmd.res_none) begin
			res_drop_q <= 1'b0;
			res_full_q <= 1'b0;
		end else if (cmd.res_full) begin
			res_drop_q <= 1'b0;
			res_full_q <= 1'b1;
		end else if (cmd.eval) begin
			res_drop_q <= drop_now;
			res_full_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_drop_q <= res_drop_q;
			out_full_q <= res_full_q;
		end
	end

endmodule

// ----- rtl/per_stream_loss_window_dropper.sv -----
// Per-stream loss window dropper, top level.
// Request channel (req): one datagram header per request. Result channel (res):
// one drop / table_full decision per request, in request order.
// Register port (cfg): index 0 loss_term_id, 1 loss_term_offset, 2 loss_length;
// always ready, other indexes ignored. Write only while no request is in flight.
// Requests that are not data frames of the loss term go straight to the result;
// the first stream into an empty table is allocated without a scan. Others scan
// the stream table one entry per cycle over the memory read port until a hit or
// the last entry in use; a hit or a new stream then goes through the window
// check, a new stream on a full table does not. A new request is taken once the
// previous result has moved to the output register. A new stream takes the
// lowest free entry; entries are freed only by reset. When the table is full a
// new stream passes with table_full set.
// Reset clears the registers to 0 and empties the table at once (fill count).
// While res is stalled one finished result waits in the output register and a
// second one waits in the result register; no further request is taken.
// Depends on pslwd_pkg, pslwd_ifs, pslwd_ctrl and pslwd_dp.
module per_stream_loss_window_dropper
	import pslwd_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	pslwd_req_if.sink    req,
	pslwd_res_if.source  res,
	pslwd_cfg_if.sink    cfg
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	dp_cmd_t       cmd;
	dp_stat_t      stat;
	logic [CW-1:0] fill;

	assign cfg.ready = 1'b1;

	pslwd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pslwd_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.frame_type        (req.frame_type),
		.frame_term_id     (req.frame_term_id),
		.frame_term_offset (req.frame_term_offset),
		.strm_id           (req.strm_id),
		.sess_id           (req.sess_id),
		.datagram_length   (req.datagram_length),
		.cmd               (cmd),
		.stat              (stat),
		.fill              (fill),
		.drop              (res.drop),
		.table_full        (res.table_full)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= CW'(TABLE_ENTRIES))
		else $error("fill count beyond table size");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.table_full |-> fill == CW'(TABLE_ENTRIES))
		else $error("table_full reported with free entries");

	a_no_drop_and_full: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.drop && res.table_full))
		else $error("drop and table_full both set");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken while one is in flight");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for per_stream_loss_window_dropper: sends datagram headers and
// register writes, predicts each drop / table_full decision and checks the results in order.
// Depends on pslwd_pkg, the channel interfaces in pslwd_ifs and the dropper RTL.
module tb;
	import pslwd_pkg::*;

	localparam int TABLE_ENTRIES = 16;
	localparam int STREAM_POOL = 20;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_OFF = 300;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam longint OFFSET_MAX = 64'h7FFF_FFFF;

	typedef struct {
		logic [15:0]        frame_type;
		logic signed [31:0] term_id;
		logic [30:0]        toff;
		logic signed [31:0] strm_id;
		logic signed [31:0] sess_id;
		logic [15:0]        length;
	} header_t;

	typedef struct {
		logic drop;
		logic table_full;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pslwd_req_if req ();
	pslwd_res_if res ();
	pslwd_cfg_if cfg ();

	per_stream_loss_window_dropper #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res),
		.cfg(cfg)
	);

	logic signed [31:0] loss_term_id_q;
	logic [30:0]        loss_offset_q;
	logic [31:0]        loss_length_q;
	logic               stream_used [TABLE_ENTRIES];
	logic [63:0]        stream_key [TABLE_ENTRIES];
	logic [32:0]        stream_track [TABLE_ENTRIES];

	logic signed [31:0] pool_stream [STREAM_POOL];
	logic signed [31:0] pool_session [STREAM_POOL];
	longint             pool_next [STREAM_POOL];

	verdict_t pending_verdicts[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off_cycles = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic header_t make_header(logic [15:0] ftype, logic [31:0] term_id,
		logic [30:0] toff, logic [31:0] strm, logic [31:0] sess,
		logic [15:0] length);
		header_t h;
		h.frame_type = ftype;
		h.term_id = term_id;
		h.toff = toff;
		h.strm_id = strm;
		h.sess_id = sess;
		h.length = length;
		return h;
	endfunction

	function automatic int find_slot(logic [31:0] strm, logic [31:0] sess);
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (stream_used[i] && stream_key[i] == {strm, sess})
				return i;
		end
		return -1;
	endfunction

	function automatic verdict_t decide_drop(header_t h);
		verdict_t v;
		logic [32:0] start;
		logic [32:0] window_end;
		logic [32:0] frame_end;
		int slot;
		int free_slot;
		v.drop = 1'b0;
		v.table_full = 1'b0;
		if (h.frame_type != DATA_FRAME_TYPE || h.term_id != loss_term_id_q)
			return v;
		start = {2'b00, h.toff};
		slot = find_slot(h.strm_id, h.sess_id);
		if (slot < 0) begin
			free_slot = -1;
			for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
				if (!stream_used[i])
					free_slot = i;
			end
			if (free_slot < 0) begin
				v.table_full = 1'b1;
				return v;
			end
			slot = free_slot;
			stream_used[slot] = 1'b1;
			stream_key[slot] = {h.strm_id, h.sess_id};
			stream_track[slot] = start;
		end
		window_end = {2'b00, loss_offset_q} + {1'b0, loss_length_q};
		frame_end = start + {17'd0, h.length};
		if (stream_track[slot] < window_end && start <= stream_track[slot] &&
			stream_track[slot] < frame_end) begin
			stream_track[slot] = frame_end;
			v.drop = 1'b1;
		end
		return v;
	endfunction

	function automatic longint start_near_window();
		longint off;
		off = longint'(loss_offset_q) - longint'($urandom_range(0, 4000));
		return (off < 0) ? 0 : off;
	endfunction

	function automatic header_t random_noise();
		header_t h;
		h = make_header(16'($urandom), $urandom, 31'($urandom), $urandom, $urandom,
			16'($urandom));
		case ($urandom_range(2))
			0: begin
				if (h.frame_type == DATA_FRAME_TYPE)
					h.frame_type = 16'd0;
				h.term_id = loss_term_id_q;
			end
			1: begin
				h.frame_type = DATA_FRAME_TYPE;
				h.term_id = loss_term_id_q ^ (32'sd1 << $urandom_range(31));
			end
			default: ;
		endcase
		return h;
	endfunction

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			res.ready <= 1'b0;
			hold_off_cycles--;
		end else begin
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (res.valid && res.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("unexpected result: drop %0b, table_full %0b", res.drop, res.table_full);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (res.drop !== want.drop) begin
					$error("drop: expected %0b, got %0b", want.drop, res.drop);
					mismatches++;
				end
				if (res.table_full !== want.table_full) begin
					$error("table_full: expected %0b, got %0b", want.table_full, res.table_full);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic send_frame(header_t h);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.frame_type <= h.frame_type;
		req.frame_term_id <= h.term_id;
		req.frame_term_offset <= h.toff;
		req.strm_id <= h.strm_id;
		req.sess_id <= h.sess_id;
		req.datagram_length <= h.length;
		do @(posedge clk); while (!req.ready);
		pending_verdicts.push_back(decide_drop(h));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (index)
			REG_LOSS_TERM_ID:     loss_term_id_q = data;
			REG_LOSS_TERM_OFFSET: loss_offset_q = data[30:0];
			REG_LOSS_LENGTH:      loss_length_q = data;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic prime_streams();
		int slot;
		for (int k = 0; k < STREAM_POOL; k++) begin
			slot = find_slot(pool_stream[k], pool_session[k]);
			pool_next[k] = (slot >= 0) ? longint'(stream_track[slot]) : start_near_window();
		end
	endtask

	task automatic run_stream_traffic(int count);
		int sent;
		int k;
		int pick;
		int slot;
		longint off;
		longint len;
		sent = 0;
		while (sent < count) begin
			k = ($urandom_range(3) == 0) ? $urandom_range(STREAM_POOL - 1) : $urandom_range(11);
			pick = $urandom_range(19);
			if (pick == 0)
				len = 0;
			else if (pick == 1)
				len = 65535;
			else if (pick == 2)
				len = longint'($urandom_range(65535));
			else
				len = longint'($urandom_range(1, 1500));
			pick = $urandom_range(99);
			if (pick >= 88) begin
				send_frame(random_noise());
				continue;
			end
			if (pick < 70) begin
				off = pool_next[k];
			end else if (pick < 80) begin
				// resend a frame that covers the tracked offset
				slot = find_slot(pool_stream[k], pool_session[k]);
				if (slot >= 0 && len > 0)
					off = longint'(stream_track[slot]) - longint'($urandom_range(0, 32'(len - 1)));
				else
					off = start_near_window();
			end else begin
				off = pool_next[k] + longint'($urandom_range(0, 6000)) - 3000;
			end
			if (off < 0)
				off = 0;
			if (off > OFFSET_MAX)
				off = start_near_window();
			if (pick < 80)
				pool_next[k] = off + len;
			send_frame(make_header(DATA_FRAME_TYPE, loss_term_id_q, off[30:0],
				pool_stream[k], pool_session[k], len[15:0]));
			sent++;
		end
	endtask

	task automatic test_ignored_frames();
		send_frame(make_header(16'd0, 32'd0, 31'd0, 32'd0, 32'd0, 16'd0));
		send_frame(make_header(16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 16'hFFFF));
		send_frame(make_header(16'd2, 32'd0, 31'd100, pool_stream[0], pool_session[0], 16'd100));
		send_frame(make_header(DATA_FRAME_TYPE, 32'd1, 31'd0, pool_stream[0], pool_session[0],
			16'd64));
		send_frame(make_header(DATA_FRAME_TYPE, 32'h8000_0000, 31'd0, pool_stream[1],
			pool_session[1], 16'd64));
	endtask

	task automatic test_window_edges();
		logic [31:0] tid;
		tid = 32'h8000_0000;
		wait_drained();
		write_reg(REG_LOSS_TERM_ID, tid);
		write_reg(REG_LOSS_TERM_OFFSET, 32'd100);
		write_reg(REG_LOSS_LENGTH, 32'd1000);
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd0, pool_stream[0], pool_session[0], 16'd100));
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd100, pool_stream[0], pool_session[0], 16'd0));
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd100, pool_stream[0], pool_session[0],
			16'd1000));
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd1100, pool_stream[0], pool_session[0],
			16'd100));
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd1099, pool_stream[1], pool_session[1], 16'd1));
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd50, pool_stream[1], pool_session[1], 16'd10));
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd2000, pool_stream[2], pool_session[2],
			16'hFFFF));
		send_frame(make_header(DATA_FRAME_TYPE, tid, 31'd1999, pool_stream[2], pool_session[2], 16'd1));
	endtask

	task automatic test_config_extremes();
		wait_drained();
		write_reg(REG_LOSS_TERM_OFFSET, 32'hFFFF_FFFF);
		write_reg(REG_LOSS_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, $urandom);
		send_frame(make_header(DATA_FRAME_TYPE, loss_term_id_q, 31'd2000, pool_stream[2],
			pool_session[2], 16'd1));
		send_frame(make_header(DATA_FRAME_TYPE, loss_term_id_q, 31'h7FFF_FFFF, pool_stream[3],
			pool_session[3], 16'hFFFF));
		send_frame(make_header(DATA_FRAME_TYPE, loss_term_id_q, 31'h7FFF_FFFF, pool_stream[3],
			pool_session[3], 16'hFFFF));
		wait_drained();
		write_reg(REG_LOSS_TERM_OFFSET, 32'd0);
		write_reg(REG_LOSS_LENGTH, 32'd0);
		write_reg(REG_LOSS_TERM_ID, 32'h7FFF_FFFF);
		send_frame(make_header(DATA_FRAME_TYPE, 32'h7FFF_FFFF, 31'd1100, pool_stream[1],
			pool_session[1], 16'd10));
		send_frame(make_header(DATA_FRAME_TYPE, 32'h7FFF_FFFF, 31'd1100, pool_stream[0],
			pool_session[0], 16'd10));
	endtask

	task automatic test_low_window();
		wait_drained();
		send_idle_pct = 16;
		recv_stall_pct = 73;
		write_reg(REG_LOSS_TERM_ID, 32'h8000_0000);
		write_reg(REG_LOSS_TERM_OFFSET, $urandom_range(0, 5000));
		write_reg(REG_LOSS_LENGTH, $urandom_range(5000, 40000));
		prime_streams();
		run_stream_traffic(210);
	endtask

	task automatic test_raised_window();
		logic [32:0] top;
		wait_drained();
		send_idle_pct = 73;
		recv_stall_pct = 16;
		top = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (stream_used[i] && stream_track[i] <= OFFSET_MAX && stream_track[i] > top)
				top = stream_track[i];
		end
		write_reg(REG_LOSS_TERM_ID, 32'h7FFF_FFFF);
		write_reg(REG_LOSS_TERM_OFFSET, top[31:0]);
		write_reg(REG_LOSS_LENGTH, $urandom_range(2000, 30000));
		prime_streams();
		run_stream_traffic(210);
	endtask

	task automatic test_saturated_window();
		wait_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_reg(REG_LOSS_TERM_ID, $urandom);
		write_reg(REG_LOSS_TERM_OFFSET, 32'h7FFF_FFFF - $urandom_range(0, 200000));
		write_reg(REG_LOSS_LENGTH, 32'hFFFF_FFFF);
		prime_streams();
		// hold the result channel so the block backs up into the request channel
		hold_off_cycles = HOLD_OFF;
		run_stream_traffic(210);
	endtask

	task automatic test_table_full();
		repeat (TABLE_ENTRIES + 3)
			send_frame(make_header(DATA_FRAME_TYPE, loss_term_id_q, 31'(start_near_window()),
				$urandom, $urandom, 16'($urandom_range(1, 1500))));
	endtask

	initial begin
		req.valid = 1'b0;
		req.frame_type = '0;
		req.frame_term_id = '0;
		req.frame_term_offset = '0;
		req.strm_id = '0;
		req.sess_id = '0;
		req.datagram_length = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		loss_term_id_q = '0;
		loss_offset_q = '0;
		loss_length_q = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			stream_used[i] = 1'b0;
		pool_stream[0] = 32'h8000_0000;
		pool_session[0] = 32'h7FFF_FFFF;
		pool_stream[1] = 32'h7FFF_FFFF;
		pool_session[1] = 32'h8000_0000;
		pool_stream[2] = 32'h0000_0000;
		pool_session[2] = 32'h0000_0000;
		pool_stream[3] = 32'hFFFF_FFFF;
		pool_session[3] = 32'hFFFF_FFFF;
		for (int k = 4; k < STREAM_POOL; k++) begin
			pool_stream[k] = $urandom;
			pool_session[k] = $urandom;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 16;
		recv_stall_pct = 73;

		test_ignored_frames();
		test_window_edges();
		test_config_extremes();
		test_low_window();
		test_raised_window();
		test_saturated_window();
		test_table_full();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
